FILE: hdl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types and constants for the tile motion alarm.
// ----------------------------------------------------------------------------
package tma_pkg;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int DIM_W   = 13;
    localparam int SUM_W   = 26;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int MASK_W  = 64;
    localparam int SENS_W  = 8;
    localparam int AREA_W  = 26;
    localparam int LIM_W   = 35;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 64;
    localparam int TILE_MAX = 64;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_AW-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_SENSITIVITY  = 3'd2,
        CFG_ALARM_LOW    = 3'd3,
        CFG_ALARM_HIGH   = 3'd4,
        CFG_ACTIVE_TILES = 3'd5
    } t_cfg_idx;

    // frame geometry seen by the front end
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] tile_w;
        logic [DIM_W-1:0] tile_h;
        logic [DIM_W-1:0] grid_w;
        logic [DIM_W-1:0] grid_h;
    } t_geom;

    // decision settings seen by the back end
    typedef struct packed {
        logic [LIM_W-1:0]  limit;
        logic [CNT_W-1:0]  alarm_low;
        logic [CNT_W-1:0]  alarm_high;
        logic [MASK_W-1:0] active;
    } t_decide;

    // one classified pixel
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] idx;
        logic             in_grid;
        logic             first;
        logic             tile_end;
        logic             frame_begin;
        logic             last;
    } t_item;

    // tile store word: previous frame sum and running sum
    typedef struct packed {
        logic [SUM_W-1:0] prev;
        logic [SUM_W-1:0] sum;
    } t_tile_word;

    typedef struct packed {
        logic              alarm;
        logic [CNT_W-1:0]  count;
        logic [MASK_W-1:0] mask;
    } t_result;

endpackage

FILE: hdl/tma_fifo.sv
// ----------------------------------------------------------------------------
// tma_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module tma_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_wdata,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_rdata,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: hdl/tma_front.sv
// ----------------------------------------------------------------------------
// tma_front
// Raster position tracking and tile classification of each pixel.
// ----------------------------------------------------------------------------
module tma_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tma_pkg::t_geom       i_geom,
    input  logic [7:0]           i_pixel,
    input  logic                 i_frame_start,
    input  logic                 i_push,
    output logic                 o_full,
    output logic                 o_item_valid,
    output tma_pkg::t_item       o_item,
    input  logic                 i_item_full
);
    import tma_pkg::*;

    logic [POS_W-1:0] r_col, r_row;
    logic             r_f1_vld;
    logic [PIX_W-1:0] r_f1_pixel;
    logic [POS_W-1:0] r_f1_col, r_f1_row;
    logic             r_f1_begin, r_f1_last;

    logic             take;
    logic [POS_W-1:0] col, row;
    logic             line_end, frame_end;

    logic [2:0]       tc, tr;
    logic [POS_W-1:0] ox, oy;
    logic             in_grid;

    // three restoring steps: quotient is below eight inside the grid
    function automatic logic [POS_W+2:0] div8(input logic [POS_W-1:0] n,
                                              input logic [DIM_W-1:0] d);
        logic [DIM_W+1:0] rem;
        logic [DIM_W+1:0] sub;
        logic [2:0]       q;
        rem = (DIM_W+2)'(n);
        q   = '0;
        for (int k = 2; k >= 0; k--) begin
            sub = (DIM_W+2)'(d) << k;
            if (rem >= sub) begin
                rem  = rem - sub;
                q[k] = 1'b1;
            end
        end
        return {q, rem[POS_W-1:0]};
    endfunction

    assign o_full = r_f1_vld && i_item_full;
    assign take   = i_push && !o_full;

    // position of the incoming pixel
    assign col       = i_frame_start ? '0 : r_col;
    assign row       = i_frame_start ? '0 : r_row;
    assign line_end  = ({1'b0, col} + DIM_W'(1)) >= i_geom.width;
    assign frame_end = ({1'b0, row} + DIM_W'(1)) >= i_geom.height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_f1_vld <= 1'b0;
        end else begin
            if (take) begin
                r_f1_vld <= 1'b1;
                if (line_end) begin
                    r_col <= '0;
                    r_row <= frame_end ? '0 : row + POS_W'(1);
                end else begin
                    r_col <= col + POS_W'(1);
                    r_row <= row;
                end
            end else if (r_f1_vld && !i_item_full) begin
                r_f1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_f1_pixel <= i_pixel;
            r_f1_col   <= col;
            r_f1_row   <= row;
            r_f1_begin <= (col == '0) && (row == '0);
            r_f1_last  <= line_end && frame_end;
        end
    end

    // tile classification
    assign {tc, ox} = div8(r_f1_col, i_geom.tile_w);
    assign {tr, oy} = div8(r_f1_row, i_geom.tile_h);
    assign in_grid  = ({1'b0, r_f1_col} < i_geom.grid_w) &&
                      ({1'b0, r_f1_row} < i_geom.grid_h);

    always_comb begin
        o_item             = '0;
        o_item.pixel       = r_f1_pixel;
        o_item.idx         = {tr, tc};
        o_item.in_grid     = in_grid;
        o_item.first       = (ox == '0) && (oy == '0);
        o_item.tile_end    = ({1'b0, ox} == i_geom.tile_w - DIM_W'(1)) &&
                             ({1'b0, oy} == i_geom.tile_h - DIM_W'(1));
        o_item.frame_begin = r_f1_begin;
        o_item.last        = r_f1_last;
    end

    assign o_item_valid = r_f1_vld;

endmodule

FILE: hdl/tma_back.sv
// ----------------------------------------------------------------------------
// tma_back
// Tile sum accumulation, frame-to-frame compare and changed tile tally.
// ----------------------------------------------------------------------------
module tma_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tma_pkg::t_decide             i_decide,
    input  logic                         i_head_valid,
    input  tma_pkg::t_item               i_head,
    output logic                         o_pop,
    input  logic [tma_pkg::OUT_CW-1:0]   i_out_count,
    output logic                         o_res_push,
    output tma_pkg::t_result             o_res
);
    import tma_pkg::*;

    localparam int PEND_W = OUT_CW + 1;

    // tile store
    t_tile_word          r_mem [TILE_MAX];
    logic [TILE_MAX-1:0] r_vbits;
    t_tile_word          r_rdata;
    logic                r_rvld;
    logic                r_fwd;
    t_tile_word          r_fwd_word;

    // stage 1: read data back, accumulate, write
    logic                r_s1_vld;
    t_item               r_s1;
    // stage 2: compare
    logic                r_s2_vld;
    logic [SUM_W-1:0]    r_s2_a, r_s2_b;
    logic [IDX_W-1:0]    r_s2_idx;
    logic                r_s2_cmp, r_s2_begin, r_s2_last;
    // stage 3: tally
    logic                r_s3_vld;
    logic [IDX_W-1:0]    r_s3_idx;
    logic                r_s3_hit, r_s3_begin, r_s3_last;

    logic [CNT_W-1:0]    r_tally;
    logic [MASK_W-1:0]   r_mask;

    logic [PEND_W-1:0]   pend;
    t_tile_word          base, wword;
    logic                we;
    logic [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]    diff;
    logic                changed;
    logic [CNT_W-1:0]    tally_nx;
    logic [MASK_W-1:0]   mask_nx, bit_sel;

    // credit check: every result in flight has a slot in the output queue
    assign pend  = PEND_W'(i_out_count)
                 + PEND_W'(r_s1_vld && r_s1.last)
                 + PEND_W'(r_s2_vld && r_s2_last)
                 + PEND_W'(r_s3_vld && r_s3_last);
    assign o_pop = i_head_valid && (pend < PEND_W'(OUT_DEPTH));

    // stage 1
    always_comb begin
        base = r_fwd ? r_fwd_word : (r_rvld ? r_rdata : '0);
        sum_new = r_s1.first ? SUM_W'(r_s1.pixel) : base.sum + SUM_W'(r_s1.pixel);
        wword.sum  = sum_new;
        wword.prev = r_s1.tile_end ? sum_new : base.prev;
        we = r_s1_vld && r_s1.in_grid;
    end

    always_ff @(posedge i_clk) begin
        r_rdata    <= r_mem[i_head.idx];
        r_fwd_word <= wword;
        if (we) begin
            r_mem[r_s1.idx] <= wword;
        end
    end

    // stage 2
    assign diff    = (r_s2_a >= r_s2_b) ? r_s2_a - r_s2_b : r_s2_b - r_s2_a;
    assign changed = LIM_W'(diff) >= i_decide.limit;

    // stage 3
    always_comb begin
        tally_nx = r_s3_begin ? '0 : r_tally;
        mask_nx  = r_s3_begin ? '0 : r_mask;
        bit_sel  = MASK_W'(1) << r_s3_idx;
        if (r_s3_hit) begin
            mask_nx = mask_nx | bit_sel;
            if (((i_decide.active & bit_sel) != '0) && (tally_nx < CNT_W'(TILE_MAX))) begin
                tally_nx = tally_nx + CNT_W'(1);
            end
        end
    end

    assign o_res_push  = r_s3_vld && r_s3_last;
    assign o_res.alarm = (tally_nx >= i_decide.alarm_low) && (tally_nx < i_decide.alarm_high);
    assign o_res.count = tally_nx;
    assign o_res.mask  = mask_nx;

    always_ff @(posedge i_clk) begin
        r_s1       <= i_head;
        r_s2_a     <= sum_new;
        r_s2_b     <= base.prev;
        r_s2_idx   <= r_s1.idx;
        r_s2_cmp   <= r_s1.in_grid && r_s1.tile_end;
        r_s2_begin <= r_s1.frame_begin;
        r_s2_last  <= r_s1.last;
        r_s3_idx   <= r_s2_idx;
        r_s3_hit   <= r_s2_cmp && changed;
        r_s3_begin <= r_s2_begin;
        r_s3_last  <= r_s2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits  <= '0;
            r_rvld   <= 1'b0;
            r_fwd    <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_tally  <= '0;
            r_mask   <= '0;
        end else begin
            r_rvld   <= r_vbits[i_head.idx];
            r_fwd    <= we && (r_s1.idx == i_head.idx);
            if (we) begin
                r_vbits[r_s1.idx] <= 1'b1;
            end
            r_s1_vld <= o_pop;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (r_s3_vld) begin
                r_tally <= tally_nx;
                r_mask  <= mask_nx;
            end
        end
    end

endmodule

FILE: hdl/tile_motion_alarm.sv
// Path: front register, middle queue, accumulate, compare and tally stages, output queue.
// Throughput: one pixel per cycle unless a full queue or the output credit check stalls.
// Reset: synchronous, active low; registers return to 640x480, sensitivity 10, window 1..64,
// all tiles active; tile sums read as zero until written, so no clearing pass is run.
// ----------------------------------------------------------------------------
// tile_motion_alarm
// Tile-sum frame differencing motion detector with a changed tile alarm window.
// ----------------------------------------------------------------------------
module tile_motion_alarm #(
    parameter int TILES_X       = 8,
    parameter int TILES_Y       = 8,
    parameter int MAX_FRAME_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input queue side
    input  logic [7:0]                    i_pixel,
    input  logic                          i_frame_start,
    input  logic                          push,
    output logic                          full,
    // result queue side
    output logic                          o_alarm,
    output logic [6:0]                    o_changed_count,
    output logic [63:0]                   o_changed_mask,
    output logic                          empty,
    input  logic                          pop,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [tma_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [tma_pkg::CFG_DW-1:0]    i_cfg_data
);
    import tma_pkg::*;

    // w / TILES is a multiply by a truncated reciprocal plus one correction
    localparam int RSH     = 16;
    localparam int RECIP_X = (1 << RSH) / TILES_X;
    localparam int RECIP_Y = (1 << RSH) / TILES_Y;
    localparam int W_RST   = 640;
    localparam int H_RST   = 480;
    localparam int TW_RST  = W_RST / TILES_X;
    localparam int TH_RST  = H_RST / TILES_Y;
    localparam int SENS_RST = 10;

    // configuration, held in the form the datapath uses
    logic [DIM_W-1:0]  r_width, r_height, r_tile_w, r_tile_h;
    logic [DIM_W-1:0]  r_grid_w, r_grid_h;
    logic [AREA_W-1:0] r_area;
    logic [LIM_W-1:0]  r_limit;
    logic [SENS_W-1:0] r_sens;
    logic [CNT_W-1:0]  r_alarm_low, r_alarm_high;
    logic [MASK_W-1:0] r_active;

    logic [DIM_W-1:0]  cfg_dim;

    t_geom             geom;
    t_decide           decide;
    logic              item_valid, item_full;
    t_item             item, head;
    logic              head_empty, head_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic              res_push;
    t_result           res, res_head;
    logic [OUT_CW-1:0] out_count;
    logic              out_full;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v < DIM_W'(8)) begin
            return DIM_W'(8);
        end else if (v > DIM_W'(MAX_FRAME_DIM)) begin
            return DIM_W'(MAX_FRAME_DIM);
        end
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] tile_len(input logic [DIM_W-1:0] v,
                                                  input logic [RSH:0]     recip,
                                                  input logic [3:0]       d);
        logic [DIM_W+RSH:0] prod;
        logic [DIM_W-1:0]   q0;
        logic [DIM_W+3:0]   back;
        logic [DIM_W-1:0]   rem;
        prod = (DIM_W+RSH+1)'(v) * (DIM_W+RSH+1)'(recip);
        q0   = prod[DIM_W+RSH-1:RSH];
        back = (DIM_W+4)'(q0) * (DIM_W+4)'(d);
        rem  = v - back[DIM_W-1:0];
        return (rem >= DIM_W'(d)) ? q0 + DIM_W'(1) : q0;
    endfunction

    assign cfg_dim = clamp_dim(i_cfg_data[DIM_W-1:0]);

    // register file; frame sizes are clamped and split into tiles on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= DIM_W'(W_RST);
            r_height     <= DIM_W'(H_RST);
            r_tile_w     <= DIM_W'(TW_RST);
            r_tile_h     <= DIM_W'(TH_RST);
            r_sens       <= SENS_W'(SENS_RST);
            r_alarm_low  <= CNT_W'(1);
            r_alarm_high <= CNT_W'(65);
            r_active     <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FRAME_WIDTH: begin
                    r_width  <= cfg_dim;
                    r_tile_w <= tile_len(cfg_dim, (RSH+1)'(RECIP_X), 4'(TILES_X));
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= cfg_dim;
                    r_tile_h <= tile_len(cfg_dim, (RSH+1)'(RECIP_Y), 4'(TILES_Y));
                end
                CFG_SENSITIVITY:  r_sens       <= i_cfg_data[SENS_W-1:0];
                CFG_ALARM_LOW:    r_alarm_low  <= i_cfg_data[CNT_W-1:0];
                CFG_ALARM_HIGH:   r_alarm_high <= i_cfg_data[CNT_W-1:0];
                CFG_ACTIVE_TILES: r_active     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived terms are registered from the config: grid and area from the tile lengths,
    // then the limit from area and sensitivity; the pipeline uses them after they update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= DIM_W'(TW_RST * TILES_X);
            r_grid_h <= DIM_W'(TH_RST * TILES_Y);
            r_area   <= AREA_W'(TW_RST * TH_RST);
            r_limit  <= LIM_W'((SENS_RST + 1) * TW_RST * TH_RST);
        end else begin
            r_grid_w <= DIM_W'(r_tile_w * DIM_W'(TILES_X));
            r_grid_h <= DIM_W'(r_tile_h * DIM_W'(TILES_Y));
            r_area   <= AREA_W'(r_tile_w) * AREA_W'(r_tile_h);
            r_limit  <= (LIM_W'(r_sens) + LIM_W'(1)) * LIM_W'(r_area);
        end
    end

    always_comb begin
        geom.width  = r_width;
        geom.height = r_height;
        geom.tile_w = r_tile_w;
        geom.tile_h = r_tile_h;
        geom.grid_w = r_grid_w;
        geom.grid_h = r_grid_h;
        decide.limit      = r_limit;
        decide.alarm_low  = r_alarm_low;
        decide.alarm_high = r_alarm_high;
        decide.active     = r_active;
    end

    // front end: position tracking and tile classification
    tma_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_push        (push),
        .o_full        (full),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_full   (item_full)
    );

    // decoupling queue between front and back
    tma_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_valid),
        .i_wdata (item),
        .o_full  (item_full),
        .i_pop   (head_pop),
        .o_rdata (head),
        .o_empty (head_empty),
        .o_count (mid_count)
    );

    // back end: accumulate, compare, tally; issues only with output room reserved
    tma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_decide     (decide),
        .i_head_valid (!head_empty && (mid_count != '0)),
        .i_head       (head),
        .o_pop        (head_pop),
        .i_out_count  (out_count),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    // result queue; the back end's credit check keeps it from overflowing
    tma_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !out_full),
        .i_wdata (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (res_head),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_alarm         = res_head.alarm;
    assign o_changed_count = res_head.count;
    assign o_changed_mask  = res_head.mask;

endmodule
